// File: design/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, types and the saturation helper for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int FRAC_BITS    = 8;
   localparam int NUM_WIDTH    = DATA_WIDTH + FRAC_BITS;
   localparam int PROD_WIDTH   = 2 * DATA_WIDTH;
   localparam int SAT_WIDTH    = PROD_WIDTH - FRAC_BITS + 1;
   localparam int ACTION_WIDTH = 4;
   // Accept edge to the edge at which the result is taken.
   localparam int PIPE_LATENCY = NUM_WIDTH + 6;

   localparam logic [DATA_WIDTH-1:0] RAW_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] RAW_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [PROD_WIDTH:0]   ROUND_HALF =
      (PROD_WIDTH+1)'(1) << (FRAC_BITS - 1);

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_ADD = 4'd0,
      ACT_SUB = 4'd1,
      ACT_MUL = 4'd2,
      ACT_DIV = 4'd3,
      ACT_MIN = 4'd4,
      ACT_MAX = 4'd5,
      ACT_INC = 4'd6,
      ACT_DEC = 4'd7,
      ACT_I2F = 4'd8,
      ACT_F2I = 4'd9
   } action_type;

   // Everything about one item except the divider's working values.
   typedef struct packed {
      logic [ACTION_WIDTH-1:0] action;
      logic                    is_less;
      logic                    is_equal;
      logic                    is_greater;
      logic                    div_by_zero;
      logic                    overflow;
      logic                    quot_neg;
      logic [DATA_WIDTH-1:0]   result;
   } side_type;

   typedef struct packed {
      side_type              side;
      logic [DATA_WIDTH-1:0] mag_a;
      logic [DATA_WIDTH-1:0] mag_b;
   } operands_type;

   typedef struct packed {
      logic                  overflow;
      logic [DATA_WIDTH-1:0] value;
   } sat_type;

   // Applies a sign to an unsigned magnitude and clamps to the signed range.
   function automatic sat_type saturate(input logic [SAT_WIDTH-1:0] mag,
                                        input logic neg);
      sat_type               res;
      logic [DATA_WIDTH-1:0] limit;
      limit = neg ? RAW_MIN : RAW_MAX;
      if (mag > SAT_WIDTH'(limit)) begin
         res.overflow = 1'b1;
         res.value    = limit;
      end else begin
         res.overflow = 1'b0;
         res.value    = neg ? (~mag[DATA_WIDTH-1:0] + 1'b1) : mag[DATA_WIDTH-1:0];
      end
      return res;
   endfunction

endpackage

// File: design/fpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front
// Input register, then the add, subtract, min, max, step and shift actions,
// compare flags and operand magnitudes for the multiplier and divider.
// ----------------------------------------------------------------------------
module fpa_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [fpa_pkg::ACTION_WIDTH-1:0] action,
   input  logic [fpa_pkg::DATA_WIDTH-1:0]  operand_a,
   input  logic [fpa_pkg::DATA_WIDTH-1:0]  operand_b,
   output logic                            out_valid,
   output fpa_pkg::operands_type           out_ops
);
   import fpa_pkg::*;

   logic                          in_valid_ff;
   logic [ACTION_WIDTH-1:0]       action_ff;
   logic signed [DATA_WIDTH-1:0]  a_ff;
   logic signed [DATA_WIDTH-1:0]  b_ff;
   logic                          ops_valid_ff;
   operands_type                  ops_ff;
   operands_type                  ops_in;
   logic signed [DATA_WIDTH-1:0]  sum;
   logic signed [DATA_WIDTH-1:0]  diff;
   logic signed [DATA_WIDTH-1:0]  shifted;

   always_comb begin
      sum     = a_ff + b_ff;
      diff    = a_ff - b_ff;
      shifted = a_ff <<< FRAC_BITS;

      ops_in                  = '0;
      ops_in.side.action      = action_ff;
      ops_in.side.is_less     = a_ff < b_ff;
      ops_in.side.is_equal    = a_ff == b_ff;
      ops_in.side.is_greater  = a_ff > b_ff;
      ops_in.side.quot_neg    = a_ff[DATA_WIDTH-1] ^ b_ff[DATA_WIDTH-1];
      ops_in.mag_a = a_ff[DATA_WIDTH-1] ? (~a_ff + 1'b1) : a_ff;
      ops_in.mag_b = b_ff[DATA_WIDTH-1] ? (~b_ff + 1'b1) : b_ff;

      case (action_ff)
         ACT_ADD: begin
            ops_in.side.result = sum;
            if (a_ff[DATA_WIDTH-1] == b_ff[DATA_WIDTH-1] &&
                sum[DATA_WIDTH-1] != a_ff[DATA_WIDTH-1]) begin
               ops_in.side.overflow = 1'b1;
               ops_in.side.result   = a_ff[DATA_WIDTH-1] ? RAW_MIN : RAW_MAX;
            end
         end
         ACT_SUB: begin
            ops_in.side.result = diff;
            if (a_ff[DATA_WIDTH-1] != b_ff[DATA_WIDTH-1] &&
                diff[DATA_WIDTH-1] != a_ff[DATA_WIDTH-1]) begin
               ops_in.side.overflow = 1'b1;
               ops_in.side.result   = a_ff[DATA_WIDTH-1] ? RAW_MIN : RAW_MAX;
            end
         end
         ACT_DIV: begin
            ops_in.side.div_by_zero = (b_ff == '0);
         end
         ACT_MIN: begin
            ops_in.side.result = (a_ff < b_ff) ? a_ff : b_ff;
         end
         ACT_MAX: begin
            ops_in.side.result = (a_ff > b_ff) ? a_ff : b_ff;
         end
         ACT_INC: begin
            if (a_ff == RAW_MAX) begin
               ops_in.side.overflow = 1'b1;
               ops_in.side.result   = RAW_MAX;
            end else begin
               ops_in.side.result = a_ff + 1'b1;
            end
         end
         ACT_DEC: begin
            if (a_ff == RAW_MIN) begin
               ops_in.side.overflow = 1'b1;
               ops_in.side.result   = RAW_MIN;
            end else begin
               ops_in.side.result = a_ff - 1'b1;
            end
         end
         ACT_I2F: begin
            // The shift is lossless only if shifting back restores the operand.
            ops_in.side.result = shifted;
            if ((shifted >>> FRAC_BITS) != a_ff) begin
               ops_in.side.overflow = 1'b1;
               ops_in.side.result   = a_ff[DATA_WIDTH-1] ? RAW_MIN : RAW_MAX;
            end
         end
         ACT_F2I: begin
            ops_in.side.result = a_ff >>> FRAC_BITS;
         end
         default: begin
            ops_in.side.result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         ops_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= accept;
         ops_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action;
      a_ff      <= operand_a;
      b_ff      <= operand_b;
      ops_ff    <= ops_in;
   end

   assign out_valid = ops_valid_ff;
   assign out_ops   = ops_ff;

endmodule

// File: design/fpa_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_mul
// Two-stage magnitude multiplier: product, then round half away from zero
// and saturate. Non-multiply items pass through unchanged.
// ----------------------------------------------------------------------------
module fpa_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  fpa_pkg::operands_type in_ops,
   output logic                  out_valid,
   output fpa_pkg::operands_type out_ops
);
   import fpa_pkg::*;

   logic                  prod_valid_ff;
   logic [PROD_WIDTH-1:0] product_ff;
   operands_type          prod_ops_ff;
   logic                  res_valid_ff;
   operands_type          res_ops_ff;
   operands_type          res_ops_in;
   logic [PROD_WIDTH:0]   rounded;
   sat_type               sat;

   always_comb begin
      rounded    = {1'b0, product_ff} + ROUND_HALF;
      sat        = saturate(rounded[PROD_WIDTH:FRAC_BITS], prod_ops_ff.side.quot_neg);
      res_ops_in = prod_ops_ff;
      if (prod_ops_ff.side.action == ACT_MUL) begin
         res_ops_in.side.result   = sat.value;
         res_ops_in.side.overflow = sat.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid;
         res_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      product_ff  <= in_ops.mag_a * in_ops.mag_b;
      prod_ops_ff <= in_ops;
      res_ops_ff  <= res_ops_in;
   end

   assign out_valid = res_valid_ff;
   assign out_ops   = res_ops_ff;

endmodule

// File: design/fpa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage, followed by a
// rounding stage and a saturate-and-select stage that forms the final result.
// ----------------------------------------------------------------------------
module fpa_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  fpa_pkg::operands_type in_ops,
   output logic                  out_valid,
   output fpa_pkg::side_type     out_side
);
   import fpa_pkg::*;

   // word starts as the shifted numerator; each stage shifts one numerator
   // bit out at the top and one quotient bit in at the bottom.
   typedef struct packed {
      side_type              side;
      logic [DATA_WIDTH-1:0] rem;
      logic [NUM_WIDTH-1:0]  word;
      logic [DATA_WIDTH-1:0] divisor;
   } div_step_type;

   typedef struct packed {
      side_type              side;
      logic [NUM_WIDTH:0]    quot;
   } round_type;

   function automatic div_step_type div_step(input div_step_type s);
      div_step_type        n;
      logic [DATA_WIDTH:0] trial;
      logic [DATA_WIDTH:0] trial_diff;
      logic                ge;
      n          = s;
      trial      = {s.rem, s.word[NUM_WIDTH-1]};
      trial_diff = trial - {1'b0, s.divisor};
      ge         = trial >= {1'b0, s.divisor};
      n.rem      = ge ? trial_diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      n.word     = {s.word[NUM_WIDTH-2:0], ge};
      return n;
   endfunction

   div_step_type           first_step;
   div_step_type           step_ff [NUM_WIDTH];
   div_step_type           step_in [NUM_WIDTH];
   logic [NUM_WIDTH-1:0]   step_valid_ff;
   round_type              round_ff;
   round_type              round_in;
   logic                   round_valid_ff;
   side_type               final_ff;
   side_type               final_in;
   logic                   final_valid_ff;
   logic                   half_up;
   sat_type                sat;

   always_comb begin
      first_step.side    = in_ops.side;
      first_step.rem     = '0;
      first_step.word    = {in_ops.mag_a, {FRAC_BITS{1'b0}}};
      first_step.divisor = in_ops.mag_b;
      step_in[0] = div_step(first_step);
      for (int k = 1; k < NUM_WIDTH; k++) begin
         step_in[k] = div_step(step_ff[k-1]);
      end
   end

   // Round half away from zero: bump the quotient when twice the
   // remainder reaches the divisor.
   always_comb begin
      half_up       = {step_ff[NUM_WIDTH-1].rem, 1'b0} >=
                      {1'b0, step_ff[NUM_WIDTH-1].divisor};
      round_in.side = step_ff[NUM_WIDTH-1].side;
      round_in.quot = {1'b0, step_ff[NUM_WIDTH-1].word} + (NUM_WIDTH+1)'(half_up);
   end

   always_comb begin
      sat      = saturate(SAT_WIDTH'(round_ff.quot), round_ff.side.quot_neg);
      final_in = round_ff.side;
      if (round_ff.side.action == ACT_DIV && !round_ff.side.div_by_zero) begin
         final_in.result   = sat.value;
         final_in.overflow = sat.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_valid_ff  <= '0;
         round_valid_ff <= 1'b0;
         final_valid_ff <= 1'b0;
      end else begin
         step_valid_ff  <= {step_valid_ff[NUM_WIDTH-2:0], in_valid};
         round_valid_ff <= step_valid_ff[NUM_WIDTH-1];
         final_valid_ff <= round_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_WIDTH; k++) begin
         step_ff[k] <= step_in[k];
      end
      round_ff <= round_in;
      final_ff <= final_in;
   end

   assign out_valid = final_valid_ff;
   assign out_side  = final_ff;

endmodule

// File: design/fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU, raw two's-complement operands with FRAC_BITS
// fraction bits: add, subtract, multiply, divide, min, max, step, and shifts.
// ----------------------------------------------------------------------------
// A new operation is taken on every cycle while reset is low; busy is high
// only during reset. Every operation, whatever its action, passes through
// the front end, the multiplier and the divider and returns its result,
// marked by rsp_valid for one cycle, in the order issued. The divider
// resolves one quotient bit per pipeline stage; all other actions ride along
// so results never reorder. The result channel has no back-pressure, so the
// receiver must take every result in the cycle it appears.
module fixed_point_alu (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [fpa_pkg::ACTION_WIDTH-1:0] req_action,
   input  logic [fpa_pkg::DATA_WIDTH-1:0]   req_operand_a,
   input  logic [fpa_pkg::DATA_WIDTH-1:0]   req_operand_b,
   output logic                             rsp_valid,
   output logic [fpa_pkg::DATA_WIDTH-1:0]   rsp_result,
   output logic                             rsp_is_less,
   output logic                             rsp_is_equal,
   output logic                             rsp_is_greater,
   output logic                             rsp_div_by_zero,
   output logic                             rsp_overflow
);
   import fpa_pkg::*;

   logic         accept;
   logic         front_valid;
   operands_type front_ops;
   logic         mul_valid;
   operands_type mul_ops;
   side_type     final_side;

   assign busy   = reset;
   assign accept = start & ~busy;

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_action),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .out_valid (front_valid),
      .out_ops   (front_ops)
   );

   fpa_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ops    (front_ops),
      .out_valid (mul_valid),
      .out_ops   (mul_ops)
   );

   fpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ops    (mul_ops),
      .out_valid (rsp_valid),
      .out_side  (final_side)
   );

   assign rsp_result      = final_side.result;
   assign rsp_is_less     = final_side.is_less;
   assign rsp_is_equal    = final_side.is_equal;
   assign rsp_is_greater  = final_side.is_greater;
   assign rsp_div_by_zero = final_side.div_by_zero;
   assign rsp_overflow    = final_side.overflow;

endmodule

// File: design/fpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [fpa_pkg::DATA_WIDTH-1:0] rsp_result,
   input logic                           rsp_valid,
   input logic                           rsp_is_less,
   input logic                           rsp_is_equal,
   input logic                           rsp_is_greater,
   input logic                           rsp_div_by_zero,
   input logic                           rsp_overflow
);
   import fpa_pkg::*;

   // Each transfer yields exactly one result after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##PIPE_LATENCY rsp_valid)
      else $error("transfer without its result");

   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without a matching transfer");

   a_one_compare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_is_less, rsp_is_equal, rsp_is_greater}))
      else $error("compare flags not exclusive");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> rsp_result == '0 && !rsp_overflow)
      else $error("divide by zero result not cleared");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_result == RAW_MAX || rsp_result == RAW_MIN)
      else $error("saturated result not at a limit");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_result      (rsp_result),
   .rsp_valid       (rsp_valid),
   .rsp_is_less     (rsp_is_less),
   .rsp_is_equal    (rsp_is_equal),
   .rsp_is_greater  (rsp_is_greater),
   .rsp_div_by_zero (rsp_div_by_zero),
   .rsp_overflow    (rsp_overflow)
);
